>>> design/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

   localparam int CHAR_W = 8;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

   function automatic logic is_alnum(input logic [CHAR_W-1:0] b);
      is_alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                 (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] b);
      if (b >= 8'h41 && b <= 8'h5A) begin
         to_lower = b + 8'h20;
      end else begin
         to_lower = b;
      end
   endfunction

endpackage

>>> design/stc_ram.sv
`timescale 1ns / 1ps

module stc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/stc_front.sv
`timescale 1ns / 1ps

module stc_front #(
   parameter int MAX_CHARS = 32,
   localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1,
   localparam int NW = $clog2(MAX_CHARS + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [stc_pkg::CHAR_W-1:0] req_char_in,
   input  logic                      req_last_in,
   output logic                      wr_en,
   output logic [AW-1:0]             wr_addr,
   output logic [stc_pkg::CHAR_W-1:0] wr_data,
   output logic                      job_push,
   output logic [NW-1:0]             job_n,
   output logic                      job_ovf,
   input  logic                      store_free
);

   logic [NW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic          hold_ff, hold_in;
   logic          accept, alnum, full;

   assign req_ready = !hold_ff;
   assign accept    = req_valid && req_ready;
   assign alnum     = stc_pkg::is_alnum(req_char_in);
   assign full      = (count_ff == NW'(MAX_CHARS));

   assign wr_en   = accept && alnum && !full;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = stc_pkg::to_lower(req_char_in);

   assign job_push = accept && req_last_in;
   assign job_n    = wr_en ? count_ff + NW'(1) : count_ff;
   assign job_ovf  = dropped_ff || (accept && alnum && full);

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      hold_in    = hold_ff;
      if (store_free) begin
         hold_in = 1'b0;
      end
      if (accept) begin
         if (req_last_in) begin
            count_in   = '0;
            dropped_in = 1'b0;
            hold_in    = 1'b1;
         end else begin
            count_in   = job_n;
            dropped_in = job_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         hold_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         hold_ff    <= hold_in;
      end
   end

   ap_no_write_while_held: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> !wr_en)
      else $error("store written while a run holds it");

endmodule

>>> design/stc_job_fifo.sv
`timescale 1ns / 1ps

module stc_job_fifo #(
   parameter int WIDTH = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff, cnt_in;

   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !(pop && pop_valid)) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && pop && pop_valid) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && pop_valid) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   ap_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (cnt_ff != 2'd2))
      else $error("job queue overrun");

endmodule

>>> design/stc_back.sv
`timescale 1ns / 1ps

module stc_back #(
   parameter int MAX_CHARS = 32,
   localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1,
   localparam int NW = $clog2(MAX_CHARS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  logic [NW-1:0]              job_n,
   input  logic                       job_ovf,
   output logic                       job_pop,
   output logic [AW-1:0]              rd_addr,
   input  logic [stc_pkg::CHAR_W-1:0] rd_data,
   output logic                       store_free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [stc_pkg::CHAR_W-1:0] rsp_char_out,
   output logic                       rsp_last_out,
   output logic                       rsp_empty_text,
   output logic                       rsp_overflow
);

   localparam int PW = NW + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_SQRT  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_LOAD  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [NW-1:0] n_ff, n_in;
   logic          ovf_ff, ovf_in;
   logic [NW-1:0] c_ff, c_in, r_ff, r_in, col_ff, col_in, row_ff, row_in;
   logic [PW-1:0] csq_ff, csq_in, rc_ff, rc_in, pos_ff, pos_in;
   logic          sep_ff, sep_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [stc_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_empty_ff, rsp_empty_in;
   logic                       rsp_ovf_ff;
   logic                       out_free, out_load;
   logic                       last_row, last_col;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_addr  = pos_ff[AW-1:0];
   assign last_row = (row_ff == r_ff - NW'(1));
   assign last_col = (col_ff == c_ff - NW'(1));

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      csq_in       = csq_ff;
      rc_in        = rc_ff;
      pos_in       = pos_ff;
      sep_in       = sep_ff;
      job_pop      = 1'b0;
      store_free   = 1'b0;
      out_load     = 1'b0;
      rsp_char_in  = stc_pkg::SPACE_CHAR;
      rsp_last_in  = 1'b0;
      rsp_empty_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               n_in     = job_n;
               ovf_in   = job_ovf;
               c_in     = NW'(1);
               csq_in   = PW'(1);
               state_in = (job_n == '0) ? ST_EMPTY : ST_SQRT;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_char_in  = stc_pkg::NUL_CHAR;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
               store_free   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SQRT: begin
            if (csq_ff < PW'(n_ff)) begin
               c_in   = c_ff + NW'(1);
               csq_in = csq_ff + (PW'(c_ff) << 1) + PW'(1);
            end else begin
               r_in     = NW'(1);
               rc_in    = PW'(c_ff);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rc_ff < PW'(n_ff)) begin
               r_in  = r_ff + NW'(1);
               rc_in = rc_ff + PW'(c_ff);
            end else begin
               col_in   = '0;
               row_in   = '0;
               pos_in   = '0;
               sep_in   = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_load = 1'b1;
               if (!sep_ff && pos_ff < PW'(n_ff)) begin
                  rsp_char_in = rd_data;
               end
               rsp_last_in = !sep_ff && last_row && last_col;
               state_in    = ST_READ;
               if (sep_ff) begin
                  sep_in = 1'b0;
                  row_in = '0;
                  pos_in = PW'(col_ff);
               end else if (last_row) begin
                  if (last_col) begin
                     store_free = 1'b1;
                     state_in   = ST_IDLE;
                  end else begin
                     col_in = col_ff + NW'(1);
                     sep_in = 1'b1;
                  end
               end else begin
                  row_in = row_ff + NW'(1);
                  pos_in = pos_ff + PW'(c_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff   <= n_in;
      ovf_ff <= ovf_in;
      c_ff   <= c_in;
      r_ff   <= r_in;
      col_ff <= col_in;
      row_ff <= row_in;
      csq_ff <= csq_in;
      rc_ff  <= rc_in;
      pos_ff <= pos_in;
      sep_ff <= sep_in;
      if (out_load) begin
         rsp_char_ff  <= rsp_char_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_out   = rsp_char_ff;
   assign rsp_last_out   = rsp_last_ff;
   assign rsp_empty_text = rsp_empty_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   ap_grid_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (col_ff < c_ff && row_ff < r_ff))
      else $error("column or row index past the grid");

   ap_free_on_last: assert property (@(posedge clock) disable iff (reset)
      store_free |=> (rsp_valid_ff && rsp_last_ff))
      else $error("store released without a final item");

   ap_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (csq_ff >= PW'(n_ff)))
      else $error("column count too small");

endmodule

>>> design/square_transposition_cipher.sv
`timescale 1ns / 1ps
// After the last byte of a nonempty text: job queue, sqrt loop (c: columns),
// divide loop (r: rows), store read, load; then the first item is ready.
// Bytes: 1 per cycle while req_ready is high; each result: store read, load
// (store read port), held while rsp_ready is low. New bytes wait from the
// last byte until the final result is loaded. Reset: synchronous, active high;
// clears counts, flags and control state. Text store contents are not cleared.

module square_transposition_cipher #(
   parameter int MAX_CHARS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [stc_pkg::CHAR_W-1:0] req_char_in,
   input  logic                       req_last_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [stc_pkg::CHAR_W-1:0] rsp_char_out,
   output logic                       rsp_last_out,
   output logic                       rsp_empty_text,
   output logic                       rsp_overflow
);

   localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam int NW = $clog2(MAX_CHARS + 1);

   logic                       wr_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [stc_pkg::CHAR_W-1:0] wr_data, rd_data;
   logic                       job_push, job_pop, job_valid, job_ovf, q_ovf;
   logic [NW-1:0]              job_n, q_n;
   logic                       store_free;

   stc_front #(.MAX_CHARS(MAX_CHARS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .req_last_in (req_last_in),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .job_push    (job_push),
      .job_n       (job_n),
      .job_ovf     (job_ovf),
      .store_free  (store_free)
   );

   stc_ram #(.WIDTH(stc_pkg::CHAR_W), .DEPTH(MAX_CHARS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stc_job_fifo #(.WIDTH(NW + 1)) u_jobs (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_ovf, job_n}),
      .pop       (job_pop),
      .pop_valid (job_valid),
      .pop_data  ({q_ovf, q_n})
   );

   stc_back #(.MAX_CHARS(MAX_CHARS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job_n          (q_n),
      .job_ovf        (q_ovf),
      .job_pop        (job_pop),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .store_free     (store_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_out   (rsp_char_out),
      .rsp_last_out   (rsp_last_out),
      .rsp_empty_text (rsp_empty_text),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

>>> tb/square_transposition_cipher_tb.sv
`timescale 1ns / 1ps

module square_transposition_cipher_tb;

   localparam int TEXT_DEPTH = 32;
   localparam int RANDOM_ITEMS = 256;

   typedef struct packed {
      logic [stc_pkg::CHAR_W-1:0] ch;
      logic                       last;
      logic                       drain;
   } msg_byte_type;

   typedef struct packed {
      logic [stc_pkg::CHAR_W-1:0] ch;
      logic                       last;
      logic                       empty;
      logic                       ovf;
   } cipher_char_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [stc_pkg::CHAR_W-1:0] req_char_in = '0;
   logic                       req_last_in = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [stc_pkg::CHAR_W-1:0] rsp_char_out;
   logic                       rsp_last_out;
   logic                       rsp_empty_text;
   logic                       rsp_overflow;

   msg_byte_type    pending_bytes[$];
   cipher_char_type ciphertext_q[$];

   // plaintext model state
   logic [stc_pkg::CHAR_W-1:0] plain_buf[TEXT_DEPTH];
   int                         plain_len = 0;
   logic                       plain_dropped = 1'b0;

   int chars_due = 0;
   int chars_seen = 0;
   int err_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int cycle_cnt = 0;

   square_transposition_cipher #(
      .MAX_CHARS(TEXT_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_in   (req_char_in),
      .req_last_in   (req_last_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_out  (rsp_last_out),
      .rsp_empty_text(rsp_empty_text),
      .rsp_overflow  (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic letter_or_digit(input logic [stc_pkg::CHAR_W-1:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A);
   endfunction

   // Updates the plaintext store and queues the ciphertext a byte triggers.
   function automatic int encipher_byte(input logic [stc_pkg::CHAR_W-1:0] b,
                                        input logic last);
      int              n;
      int              cols;
      int              rows;
      int              total;
      int              k;
      int              pos;
      logic            ovf;
      cipher_char_type res;
      k = 0;
      if (letter_or_digit(b)) begin
         if (plain_len < TEXT_DEPTH) begin
            plain_buf[plain_len] = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
            plain_len++;
         end else begin
            plain_dropped = 1'b1;
         end
      end
      if (!last) return 0;
      n = plain_len;
      ovf = plain_dropped;
      plain_len = 0;
      plain_dropped = 1'b0;
      if (n == 0) begin
         ciphertext_q.push_back('{ch: stc_pkg::NUL_CHAR, last: 1'b1, empty: 1'b1, ovf: ovf});
         return 1;
      end
      cols = 1;
      while (cols * cols < n) cols++;
      rows = (n + cols - 1) / cols;
      total = cols * rows + cols - 1;
      for (int col = 0; col < cols; col++) begin
         if (col > 0) begin
            ciphertext_q.push_back('{ch: stc_pkg::SPACE_CHAR, last: 1'b0, empty: 1'b0,
                                     ovf: ovf});
            k++;
         end
         for (int row = 0; row < rows; row++) begin
            pos = row * cols + col;
            res.ch = (pos < n) ? plain_buf[pos] : stc_pkg::SPACE_CHAR;
            res.last = (k + 1 == total);
            res.empty = 1'b0;
            res.ovf = ovf;
            ciphertext_q.push_back(res);
            k++;
         end
      end
      return k;
   endfunction

   // sender: bursts with random gaps; some items wait for the pipe to drain
   always @(posedge clock) begin : driver
      logic         fire;
      logic         show;
      int           due_now;
      msg_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && req_ready;
         due_now = chars_due;
         if (fire) begin
            due_now = chars_due + encipher_byte(req_char_in, req_last_in);
         end
         chars_due <= due_now;
         show = req_valid && !fire;
         if (!show && pending_bytes.size() != 0) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (!(pending_bytes[0].drain && due_now != chars_seen)) begin
               nxt = pending_bytes.pop_front();
               req_char_in <= nxt.ch;
               req_last_in <= nxt.last;
               show = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
         req_valid <= show;
      end
   end

   // receiver: rotates through ready, random, periodic and long-stall phases
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      case ((cycle_cnt / 300) % 4)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= (cycle_cnt % 5) != 0;
         end
         default: begin
            if (stall_left != 0) begin
               stall_left <= stall_left - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 12);
            end
         end
      endcase
   end

   always @(posedge clock) begin : monitor
      cipher_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         chars_seen <= chars_seen + 1;
         if (ciphertext_q.size() == 0) begin
            $error("unexpected item: char_out %02h last_out %0b", rsp_char_out, rsp_last_out);
            err_count++;
         end else begin
            want = ciphertext_q.pop_front();
            if (rsp_char_out !== want.ch) begin
               $error("char_out: expected %02h, got %02h", want.ch, rsp_char_out);
               err_count++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out: expected %0b, got %0b", want.last, rsp_last_out);
               err_count++;
            end
            if (rsp_empty_text !== want.empty) begin
               $error("empty_text: expected %0b, got %0b", want.empty, rsp_empty_text);
               err_count++;
            end
            if (rsp_overflow !== want.ovf) begin
               $error("overflow: expected %0b, got %0b", want.ovf, rsp_overflow);
               err_count++;
            end
         end
      end
   end

   function automatic logic [stc_pkg::CHAR_W-1:0] rand_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 36) return 8'(8'h41 + r - 10);
      return 8'(8'h61 + r - 36);
   endfunction

   task automatic queue_byte(input logic [stc_pkg::CHAR_W-1:0] b, input logic last,
                             input logic drain = 1'b0);
      pending_bytes.push_back('{ch: b, last: last, drain: drain});
   endtask

   initial begin : stimulus
      int                         added;
      int                         kind;
      int                         len;
      logic                       drain;
      logic [stc_pkg::CHAR_W-1:0] b;

      // empty text, single char
      queue_byte(8'h20, 1'b1, 1'b1);
      queue_byte(8'h41, 1'b1, 1'b1);
      // class boundaries, non-ASCII bytes
      queue_byte(8'h2F, 1'b0, 1'b1);
      queue_byte(8'h30, 1'b0);
      queue_byte(8'h39, 1'b0);
      queue_byte(8'h3A, 1'b0);
      queue_byte(8'h40, 1'b0);
      queue_byte(8'h5A, 1'b0);
      queue_byte(8'h5B, 1'b0);
      queue_byte(8'h60, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h7A, 1'b0);
      queue_byte(8'h7B, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h4D, 1'b1);
      // empty text from NUL bytes
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      // padded last column
      queue_byte(8'h62, 1'b0, 1'b1);
      queue_byte(8'h43, 1'b0);
      queue_byte(8'h64, 1'b0);
      queue_byte(8'h45, 1'b0);
      queue_byte(8'h66, 1'b1);

      added = 0;
      while (added < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         drain = ($urandom_range(0, 7) == 0);
         if (kind < 6) len = $urandom_range(1, 16);
         else if (kind == 6) len = $urandom_range(17, 33);
         else if (kind == 7) len = $urandom_range(30, 40);
         else len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            if (kind >= 8 || $urandom_range(0, (kind == 7) ? 15 : 4) == 0) begin
               b = 8'($urandom_range(0, 255));
            end else begin
               b = rand_alnum();
            end
            queue_byte(b, i == len - 1, drain && i == 0);
         end
         added += len;
      end

      @(negedge reset);
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || chars_due != chars_seen);
      repeat (100) @(posedge clock);
      if (ciphertext_q.size() != 0) begin
         $error("%0d expected items never arrived", ciphertext_q.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
